// ===== rtl/mrfc_pkg.sv =====
`timescale 1ns / 1ps

package mrfc_pkg;

  // Longest frame accepted, in bytes.
  localparam int MAX_FRAME = 256;
  localparam int CNT_W     = 9;

  localparam logic [CNT_W-1:0] MAX_LEN      = CNT_W'(MAX_FRAME);
  localparam logic [CNT_W-1:0] MIN_REQ_LEN  = 9'd4;
  localparam logic [CNT_W-1:0] EXC_LEN      = 9'd5;
  localparam logic [CNT_W-1:0] READ_HDR_LEN = 9'd5;
  localparam logic [CNT_W-1:0] FIXED_LEN    = 9'd8;
  localparam logic [CNT_W-1:0] CRC_BYTES    = 9'd2;

  localparam logic [7:0] EXC_FLAG = 8'h80;

  localparam logic [7:0] FN_READ_COILS     = 8'd1;
  localparam logic [7:0] FN_READ_INPUT_REG = 8'd4;
  localparam logic [7:0] FN_WRITE_COIL     = 8'd5;
  localparam logic [7:0] FN_WRITE_REG      = 8'd6;
  localparam logic [7:0] FN_WRITE_COILS    = 8'd15;
  localparam logic [7:0] FN_WRITE_REGS     = 8'd16;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_BYTE  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    V_INCOMPLETE = 2'd0,
    V_COMPLETE   = 2'd1,
    V_MALFORMED  = 2'd2
  } verdict_t;

  typedef struct packed {
    verdict_t         verdict;
    logic             length_known;
    logic [CNT_W-1:0] resp_length;
    logic [CNT_W-1:0] bytes_seen;
  } result_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic is_fixed_fn(input logic [7:0] f);
    return (f == FN_WRITE_COIL) || (f == FN_WRITE_REG) ||
           (f == FN_WRITE_COILS) || (f == FN_WRITE_REGS);
  endfunction

  function automatic logic is_read_fn(input logic [7:0] f);
    return (f >= FN_READ_COILS) && (f <= FN_READ_INPUT_REG);
  endfunction

endpackage

// ===== rtl/mrfc_tracker.sv =====
`timescale 1ns / 1ps

module mrfc_tracker import mrfc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  logic             command,
  input  logic [7:0]       request_unit,
  input  logic [7:0]       request_function,
  input  logic [CNT_W-1:0] req_length,
  input  logic [7:0]       data_byte,
  output result_t          result
);

  logic [7:0]       saved_unit, saved_function, reply_function, crc_low_received;
  logic             request_bad, unit_mismatch, expected_known;
  logic [CNT_W-1:0] byte_counter, expected_length;
  logic [15:0]      running_crc, frozen_crc;

  logic [7:0]       reply_function_next, crc_low_received_next;
  logic             unit_mismatch_next, expected_known_next;
  logic [CNT_W-1:0] byte_counter_next, expected_length_next;
  logic [15:0]      running_crc_next, frozen_crc_next;

  logic [7:0]       exc;
  logic [CNT_W-1:0] idx, n, exp_len;
  logic [15:0]      got;

  assign exc = saved_function | EXC_FLAG;
  assign idx = byte_counter;

  // Frame state update for one response byte.
  always_comb begin
    byte_counter_next     = byte_counter;
    unit_mismatch_next    = unit_mismatch;
    reply_function_next   = reply_function;
    expected_length_next  = expected_length;
    expected_known_next   = expected_known;
    running_crc_next      = running_crc;
    frozen_crc_next       = frozen_crc;
    crc_low_received_next = crc_low_received;
    if (idx <= MAX_LEN) begin
      byte_counter_next = idx + 9'd1;
      if (idx == 9'd0) begin
        unit_mismatch_next = (data_byte != saved_unit);
      end else if (idx == 9'd1) begin
        reply_function_next = data_byte;
        if (data_byte == exc) begin
          expected_length_next = EXC_LEN;
          expected_known_next  = 1'b1;
        end else if (data_byte == saved_function && is_fixed_fn(data_byte)) begin
          expected_length_next = FIXED_LEN;
          expected_known_next  = 1'b1;
        end
      end else if (idx == 9'd2 && reply_function != exc &&
                   reply_function == saved_function && is_read_fn(saved_function)) begin
        expected_length_next = READ_HDR_LEN + {1'b0, data_byte};
        expected_known_next  = (expected_length_next <= MAX_LEN);
      end
      if (expected_known_next && idx == expected_length_next - CRC_BYTES) begin
        frozen_crc_next       = running_crc;
        crc_low_received_next = data_byte;
      end
      running_crc_next = crc_byte(running_crc, data_byte);
    end
  end

  // Verdict on the prefix including this byte.
  assign n   = byte_counter_next;
  assign got = {data_byte, crc_low_received_next};

  always_comb begin
    result.verdict      = V_INCOMPLETE;
    result.length_known = 1'b0;
    result.resp_length  = '0;
    result.bytes_seen   = n;
    exp_len             = '0;
    if (request_bad || n > MAX_LEN) begin
      result.verdict = V_MALFORMED;
    end else if (n < 9'd2) begin
      result.verdict = V_INCOMPLETE;
    end else if (unit_mismatch_next) begin
      result.verdict = V_MALFORMED;
    end else begin
      if (reply_function_next == exc) begin
        exp_len = EXC_LEN;
      end else if (reply_function_next != saved_function) begin
        result.verdict = V_MALFORMED;
      end else if (is_read_fn(saved_function)) begin
        if (n >= 9'd3) begin
          if (expected_length_next > MAX_LEN) begin
            result.verdict = V_MALFORMED;
          end else begin
            exp_len = expected_length_next;
          end
        end
      end else if (is_fixed_fn(saved_function)) begin
        exp_len = FIXED_LEN;
      end else begin
        result.verdict = V_MALFORMED;
      end
      if (exp_len != '0) begin
        result.length_known = 1'b1;
        result.resp_length  = exp_len;
        if (n < exp_len) begin
          result.verdict = V_INCOMPLETE;
        end else if (n != exp_len) begin
          result.verdict = V_MALFORMED;
        end else begin
          result.verdict = (got == frozen_crc_next) ? V_COMPLETE : V_MALFORMED;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      saved_unit       <= '0;
      saved_function   <= '0;
      request_bad      <= 1'b0;
      byte_counter     <= '0;
      unit_mismatch    <= 1'b0;
      reply_function   <= '0;
      expected_length  <= '0;
      expected_known   <= 1'b0;
      running_crc      <= CRC_INIT;
      frozen_crc       <= '0;
      crc_low_received <= '0;
    end else if (take) begin
      if (command == CMD_START) begin
        saved_unit       <= request_unit;
        saved_function   <= request_function;
        request_bad      <= (req_length < MIN_REQ_LEN) || (req_length > MAX_LEN);
        byte_counter     <= '0;
        unit_mismatch    <= 1'b0;
        reply_function   <= '0;
        expected_length  <= '0;
        expected_known   <= 1'b0;
        running_crc      <= CRC_INIT;
        frozen_crc       <= '0;
        crc_low_received <= '0;
      end else begin
        byte_counter     <= byte_counter_next;
        unit_mismatch    <= unit_mismatch_next;
        reply_function   <= reply_function_next;
        expected_length  <= expected_length_next;
        expected_known   <= expected_known_next;
        running_crc      <= running_crc_next;
        frozen_crc       <= frozen_crc_next;
        crc_low_received <= crc_low_received_next;
      end
    end
  end

endmodule

// ===== rtl/mrfc_out_stage.sv =====
`timescale 1ns / 1ps

module mrfc_out_stage import mrfc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  logic    has_result,
  input  result_t result,
  output logic    can_load,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t held
);

  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= load && has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load && has_result) begin
      held <= result;
    end
  end

endmodule

// ===== rtl/modbus_rtu_response_frame_checker.sv =====
`timescale 1ns / 1ps
// Modbus RTU response frame checker.
// Input channel (in_valid/in_ready): each beat is either a start of a new
// request (command 0: request_unit, request_function, req_length) or one
// received response byte (command 1: data_byte).
// Output channel (out_valid/out_ready): one beat per response byte carrying
// verdict (incomplete/complete/malformed), length_known, resp_length and
// bytes_seen for the prefix received so far. A start beat gives no output.
// The result of a byte is registered and shows on the output in the cycle
// after the byte is accepted. Throughput: one byte per cycle unless stalled;
// frame state and byte-wide CRC-16 step update in the cycle a byte is taken.
// Stalls: in_ready is high whenever the output register is empty or being
// drained this cycle, so a held result blocks intake only while out_ready
// is low; nothing is dropped.
// Reset (rst, synchronous): output register empties and the frame state
// returns to an implicit valid request for unit 0, function 0, CRC 0xFFFF.
module modbus_rtu_response_frame_checker import mrfc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             command,
  input  logic [7:0]       request_unit,
  input  logic [7:0]       request_function,
  input  logic [CNT_W-1:0] req_length,
  input  logic [7:0]       data_byte,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       verdict,
  output logic             length_known,
  output logic [CNT_W-1:0] resp_length,
  output logic [CNT_W-1:0] bytes_seen
);

  logic    take;
  result_t result, held;

  assign take = in_valid && in_ready;

  // frame tracking, CRC and verdict
  mrfc_tracker u_tracker (
    .clk              (clk),
    .rst              (rst),
    .take             (take),
    .command          (command),
    .request_unit     (request_unit),
    .request_function (request_function),
    .req_length       (req_length),
    .data_byte        (data_byte),
    .result           (result)
  );

  // result register; only byte beats produce a result
  mrfc_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (take),
    .has_result (command == CMD_BYTE),
    .result     (result),
    .can_load   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .held       (held)
  );

  assign verdict      = held.verdict;
  assign length_known = held.length_known;
  assign resp_length  = held.resp_length;
  assign bytes_seen   = held.bytes_seen;

endmodule

// ===== rtl/mrfc_checker.sv =====
`timescale 1ns / 1ps

module mrfc_checker import mrfc_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             command,
  input logic             out_valid,
  input logic             out_ready,
  input logic [1:0]       verdict,
  input logic             length_known,
  input logic [CNT_W-1:0] resp_length,
  input logic [CNT_W-1:0] bytes_seen
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(verdict) && $stable(bytes_seen))
    else $error("output beat changed while stalled");

  a_complete: assert property (@(posedge clk) disable iff (rst)
    out_valid && verdict == V_COMPLETE |-> length_known && resp_length == bytes_seen)
    else $error("complete verdict without matching length");

  a_unknown: assert property (@(posedge clk) disable iff (rst)
    out_valid && !length_known |-> resp_length == '0)
    else $error("frame length reported while unknown");

  a_start: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && command == CMD_START |=> !out_valid)
    else $error("start beat produced a result");

endmodule

bind modbus_rtu_response_frame_checker mrfc_checker u_mrfc_checker (.*);
